>>> hdl/brf_pkg.sv
// shared types, constants and helpers for the byte ring fifo
package brf_pkg;

  localparam int SLOTS     = 256;
  localparam int MAX_BURST = 64;
  localparam int PTR_W     = $clog2(SLOTS);
  localparam int HELD_W    = (PTR_W + 1 > 9) ? PTR_W + 1 : 9;
  localparam int BYTE_W    = 8;
  localparam int ACT_W     = 2;
  localparam int CNT_W     = 7;
  localparam int OCC_W     = 8;
  localparam int QDEPTH    = 2;
  localparam int QPTR_W    = $clog2(QDEPTH);
  localparam int QCNT_W    = $clog2(QDEPTH + 1);

  typedef enum logic [ACT_W-1:0] {
    ACT_WRITE = 2'd0,
    ACT_READ  = 2'd1,
    ACT_CLEAR = 2'd2,
    ACT_QUERY = 2'd3
  } brf_act_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_WAIT
  } brf_state_t;

  typedef struct packed {
    brf_act_t          act;
    logic [BYTE_W-1:0] wbyte;
    logic [CNT_W-1:0]  count;
  } brf_cmd_t;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    r = (p == PTR_W'(SLOTS - 1)) ? '0 : p + 1'b1;
    return r;
  endfunction

  function automatic logic [HELD_W-1:0] held_of(input logic [PTR_W-1:0] wp,
                                                input logic [PTR_W-1:0] rp);
    logic [HELD_W-1:0] h;
    if (wp >= rp) begin
      h = HELD_W'(wp) - HELD_W'(rp);
    end else begin
      h = HELD_W'(wp) + HELD_W'(SLOTS) - HELD_W'(rp);
    end
    return h;
  endfunction

  function automatic logic [OCC_W-1:0] occ_sat(input logic [HELD_W-1:0] h);
    logic [OCC_W-1:0] o;
    o = (h > HELD_W'(255)) ? OCC_W'(255) : OCC_W'(h);
    return o;
  endfunction

endpackage

>>> hdl/brf_ram.sv
// generic single write port ram with registered read
module brf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> hdl/brf_front.sv
// front end: takes input beats, decodes them and queues commands
module brf_front import brf_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [ACT_W-1:0]  in_action,
  input  logic [BYTE_W-1:0] in_write_byte,
  input  logic [CNT_W-1:0]  in_read_count,
  output logic              cmd_valid,
  output brf_cmd_t          cmd,
  input  logic              cmd_pop
);

  brf_cmd_t          q_r [QDEPTH];
  logic [QPTR_W-1:0] head_r, head_nxt;
  logic [QPTR_W-1:0] tail_r, tail_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              push;
  brf_cmd_t          dec;

  always_comb begin
    dec.wbyte = in_write_byte;
    dec.count = (in_read_count > CNT_W'(MAX_BURST)) ? CNT_W'(MAX_BURST) : in_read_count;
    unique case (in_action)
      ACT_WRITE: dec.act = ACT_WRITE;
      ACT_READ:  dec.act = ACT_READ;
      ACT_CLEAR: dec.act = ACT_CLEAR;
      default:   dec.act = ACT_QUERY;
    endcase
  end

  assign in_stall  = (cnt_r == QCNT_W'(QDEPTH));
  assign push      = in_valid && !in_stall;
  assign cmd_valid = (cnt_r != '0);
  assign cmd       = q_r[head_r];

  always_comb begin
    head_nxt = head_r;
    tail_nxt = tail_r;
    cnt_nxt  = cnt_r;
    if (push) begin
      tail_nxt = (tail_r == QPTR_W'(QDEPTH - 1)) ? '0 : tail_r + 1'b1;
    end
    if (cmd_pop) begin
      head_nxt = (head_r == QPTR_W'(QDEPTH - 1)) ? '0 : head_r + 1'b1;
    end
    if (push && !cmd_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!push && cmd_pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
      cnt_r  <= '0;
    end else begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[tail_r] <= dec;
    end
  end

endmodule

>>> hdl/brf_back.sv
// back end: pointers, byte store and result register
module brf_back import brf_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cmd_valid,
  input  brf_cmd_t          cmd,
  output logic              cmd_pop,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [BYTE_W-1:0] out_read_byte,
  output logic              out_byte_valid,
  output logic              out_last_of_run,
  output logic [OCC_W-1:0]  out_occupancy,
  output logic              out_overflow
);

  brf_state_t        state_r, state_nxt;
  logic [PTR_W-1:0]  rp_r, rp_nxt;
  logic [PTR_W-1:0]  wp_r, wp_nxt;
  logic [CNT_W-1:0]  rem_r, rem_nxt;
  logic              last_r, last_nxt;

  logic              ov_r, ov_nxt;
  logic [BYTE_W-1:0] ob_r, ob_nxt;
  logic              obv_r, obv_nxt;
  logic              olast_r, olast_nxt;
  logic [OCC_W-1:0]  oocc_r, oocc_nxt;
  logic              oovf_r, oovf_nxt;
  logic              load;

  logic              out_free;
  logic [HELD_W-1:0] held;
  logic              full;
  logic [CNT_W-1:0]  n_rd;
  logic              ram_we, ram_re;
  logic [BYTE_W-1:0] ram_rdata;

  assign out_free = !ov_r || !out_stall;
  assign held     = held_of(wp_r, rp_r);
  assign full     = (held >= HELD_W'(SLOTS - 1));
  assign n_rd     = (HELD_W'(cmd.count) > held) ? CNT_W'(held) : cmd.count;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (cmd_valid && out_free && cmd.act == ACT_READ && n_rd != '0) begin
          state_nxt = ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        if (out_free) begin
          state_nxt = ST_WAIT;
        end
      end
      ST_WAIT: begin
        state_nxt = last_r ? ST_IDLE : ST_ISSUE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath and result register
  always_comb begin
    cmd_pop  = 1'b0;
    rp_nxt   = rp_r;
    wp_nxt   = wp_r;
    rem_nxt  = rem_r;
    last_nxt = last_r;
    ram_we   = 1'b0;
    ram_re   = 1'b0;
    load     = 1'b0;
    obv_nxt  = 1'b0;
    ob_nxt   = '0;
    olast_nxt = 1'b1;
    oovf_nxt = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (cmd_valid && out_free) begin
          cmd_pop = 1'b1;
          unique case (cmd.act)
            ACT_WRITE: begin
              load = 1'b1;
              if (full) begin
                oovf_nxt = 1'b1;
              end else begin
                ram_we = 1'b1;
                wp_nxt = ptr_inc(wp_r);
              end
            end
            ACT_READ: begin
              if (n_rd == '0) begin
                load = 1'b1;
              end else begin
                rem_nxt = n_rd;
              end
            end
            ACT_CLEAR: begin
              load   = 1'b1;
              rp_nxt = '0;
              wp_nxt = '0;
            end
            default: load = 1'b1;
          endcase
        end
      end
      ST_ISSUE: begin
        if (out_free) begin
          ram_re   = 1'b1;
          rp_nxt   = ptr_inc(rp_r);
          rem_nxt  = rem_r - 1'b1;
          last_nxt = (rem_r == CNT_W'(1));
        end
      end
      ST_WAIT: begin
        // result register is empty here: nothing loads it while the read is out
        load      = 1'b1;
        obv_nxt   = 1'b1;
        ob_nxt    = ram_rdata;
        olast_nxt = last_r;
      end
      default: ;
    endcase
    oocc_nxt = occ_sat(held_of(wp_nxt, rp_nxt));
    if (load) begin
      ov_nxt = 1'b1;
    end else if (!out_stall) begin
      ov_nxt = 1'b0;
    end else begin
      ov_nxt = ov_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      rp_r    <= '0;
      wp_r    <= '0;
      rem_r   <= '0;
      last_r  <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      rp_r    <= rp_nxt;
      wp_r    <= wp_nxt;
      rem_r   <= rem_nxt;
      last_r  <= last_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      ob_r    <= ob_nxt;
      obv_r   <= obv_nxt;
      olast_r <= olast_nxt;
      oocc_r  <= oocc_nxt;
      oovf_r  <= oovf_nxt;
    end
  end

  brf_ram #(
    .WIDTH(BYTE_W),
    .DEPTH(SLOTS)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(wp_r),
    .wdata(cmd.wbyte),
    .re   (ram_re),
    .raddr(rp_r),
    .rdata(ram_rdata)
  );

  assign out_valid       = ov_r;
  assign out_read_byte   = ob_r;
  assign out_byte_valid  = obv_r;
  assign out_last_of_run = olast_r;
  assign out_occupancy   = oocc_r;
  assign out_overflow    = oovf_r;

endmodule

>>> hdl/byte_ring_fifo_top.sv
// top level of the byte ring fifo
//
//  channel  direction  handshake          payload
//  in_      input      in_valid/in_stall  action, write_byte, read_count
//  out_     output     out_valid/out_stall read_byte, byte_valid, last_of_run,
//                                          occupancy, overflow
//
// write, clear and query each give one result beat from the back end; a read run
// gives one beat per byte, each byte passing through the registered store read into
// the single result register, and no new command is taken until the run is done.
// a two-entry command queue lets input beats be taken while the back end is busy.
// reset is synchronous on rst_n and empties the fifo; the store itself is not cleared.
// out_stall holds the result register and, behind it, the whole back end.
module byte_ring_fifo_top import brf_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [ACT_W-1:0]  in_action,
  input  logic [BYTE_W-1:0] in_write_byte,
  input  logic [CNT_W-1:0]  in_read_count,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [BYTE_W-1:0] out_read_byte,
  output logic              out_byte_valid,
  output logic              out_last_of_run,
  output logic [OCC_W-1:0]  out_occupancy,
  output logic              out_overflow
);

  logic     cmd_valid;
  logic     cmd_pop;
  brf_cmd_t cmd;

  brf_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_action    (in_action),
    .in_write_byte(in_write_byte),
    .in_read_count(in_read_count),
    .cmd_valid    (cmd_valid),
    .cmd          (cmd),
    .cmd_pop      (cmd_pop)
  );

  brf_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd_valid      (cmd_valid),
    .cmd            (cmd),
    .cmd_pop        (cmd_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_read_byte  (out_read_byte),
    .out_byte_valid (out_byte_valid),
    .out_last_of_run(out_last_of_run),
    .out_occupancy  (out_occupancy),
    .out_overflow   (out_overflow)
  );

endmodule

>>> hdl/brf_chk.sv
// port level checks for the byte ring fifo, bound to the top level
module brf_chk import brf_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_stall,
  input logic [BYTE_W-1:0] out_read_byte,
  input logic              out_byte_valid,
  input logic              out_last_of_run,
  input logic              out_overflow
);

  // a beat with no popped byte carries a zero byte
  a_zero_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_byte_valid |-> out_read_byte == '0)
    else $error("non-popped beat carries a byte");

  // only a popped byte can be followed by more beats of the same item
  a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_byte_valid |-> out_last_of_run)
    else $error("non-byte beat not marked last");

  // a dropped write is never a byte beat
  a_ovf_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_overflow |-> !out_byte_valid && out_last_of_run)
    else $error("overflow on a byte beat");

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_read_byte)
      && $stable(out_last_of_run))
    else $error("stalled result changed");

endmodule

bind byte_ring_fifo_top brf_chk u_brf_chk (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_read_byte  (out_read_byte),
  .out_byte_valid (out_byte_valid),
  .out_last_of_run(out_last_of_run),
  .out_overflow   (out_overflow)
);

>>> bench/tb_byte_ring_fifo_top.sv
// testbench for byte_ring_fifo_top: directed and random beats checked against a ring-buffer predictor
module tb_byte_ring_fifo_top import brf_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 3000000;
  localparam int RANDOM_ITEMS = 370;
  localparam int CALM_TAIL = 40;
  localparam int SETTLE_CYCLES = 20;

  typedef struct {
    logic [BYTE_W-1:0] rbyte;
    logic              bvalid;
    logic              last;
    logic [OCC_W-1:0]  occ;
    logic              ovf;
  } fifo_result_t;

  class ring_scoreboard;
    fifo_result_t      expected_results[$];
    logic [BYTE_W-1:0] ring_bytes [SLOTS];
    int                rd_idx;
    int                wr_idx;
    int                errors;

    function new();
      rd_idx = 0;
      wr_idx = 0;
      errors = 0;
    endfunction

    function int held();
      return (wr_idx + SLOTS - rd_idx) % SLOTS;
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    function void add_result(logic [BYTE_W-1:0] b, logic v, logic l, logic o);
      fifo_result_t r;
      int h;
      h = held();
      r.rbyte = b;
      r.bvalid = v;
      r.last = l;
      r.occ = (h > 255) ? OCC_W'(255) : OCC_W'(h);
      r.ovf = o;
      expected_results.push_back(r);
    endfunction

    // advance the predicted fifo by one accepted input beat
    function void predict_action(brf_act_t act, logic [BYTE_W-1:0] wbyte,
                                 logic [CNT_W-1:0] count);
      int n;
      case (act)
        ACT_WRITE: begin
          if (held() >= SLOTS - 1) begin
            add_result('0, 1'b0, 1'b1, 1'b1);
          end else begin
            ring_bytes[wr_idx] = wbyte;
            wr_idx = (wr_idx + 1) % SLOTS;
            add_result('0, 1'b0, 1'b1, 1'b0);
          end
        end
        ACT_READ: begin
          n = int'(count);
          if (n > MAX_BURST) n = MAX_BURST;
          if (n > held()) n = held();
          if (n == 0) begin
            add_result('0, 1'b0, 1'b1, 1'b0);
          end else begin
            for (int i = 0; i < n; i++) begin
              logic [BYTE_W-1:0] b;
              b = ring_bytes[rd_idx];
              rd_idx = (rd_idx + 1) % SLOTS;
              add_result(b, 1'b1, (i + 1 == n), 1'b0);
            end
          end
        end
        ACT_CLEAR: begin
          rd_idx = 0;
          wr_idx = 0;
          add_result('0, 1'b0, 1'b1, 1'b0);
        end
        default: begin
          add_result('0, 1'b0, 1'b1, 1'b0);
        end
      endcase
    endfunction

    task report(string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      errors++;
    endtask

    task check_result(logic [BYTE_W-1:0] b, logic v, logic l, logic [OCC_W-1:0] occ,
                      logic o);
      fifo_result_t e;
      if (expected_results.size() == 0) begin
        report($sformatf("unexpected result beat byte=%h occ=%0d", b, occ));
      end else begin
        e = expected_results.pop_front();
        if (b !== e.rbyte)
          report($sformatf("read_byte got %h exp %h", b, e.rbyte));
        if (v !== e.bvalid)
          report($sformatf("byte_valid got %b exp %b", v, e.bvalid));
        if (l !== e.last)
          report($sformatf("last_of_run got %b exp %b", l, e.last));
        if (occ !== e.occ)
          report($sformatf("occupancy got %0d exp %0d", occ, e.occ));
        if (o !== e.ovf)
          report($sformatf("overflow got %b exp %b", o, e.ovf));
      end
    endtask
  endclass

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  logic [ACT_W-1:0]  in_action;
  logic [BYTE_W-1:0] in_write_byte;
  logic [CNT_W-1:0]  in_read_count;
  logic              out_valid;
  logic              out_stall;
  logic [BYTE_W-1:0] out_read_byte;
  logic              out_byte_valid;
  logic              out_last_of_run;
  logic [OCC_W-1:0]  out_occupancy;
  logic              out_overflow;

  ring_scoreboard sb;
  bit             idle_on;
  int             cycles;
  int             rand_items;

  byte_ring_fifo_top DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_action      (in_action),
    .in_write_byte  (in_write_byte),
    .in_read_count  (in_read_count),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_read_byte  (out_read_byte),
    .out_byte_valid (out_byte_valid),
    .out_last_of_run(out_last_of_run),
    .out_occupancy  (out_occupancy),
    .out_overflow   (out_overflow)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("== FAIL ==");
    $finish;
  end

  // result side back-pressure in bursts
  initial begin
    out_stall = 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (idle_on && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 11)) @(posedge clk);
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end else begin
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_result(out_read_byte, out_byte_valid, out_last_of_run, out_occupancy,
                      out_overflow);
  end

  task automatic send_beat(brf_act_t act, logic [BYTE_W-1:0] wbyte,
                           logic [CNT_W-1:0] count);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_action     <= act;
    in_write_byte <= wbyte;
    in_read_count <= count;
    do @(posedge clk); while (in_stall);
    sb.predict_action(act, wbyte, count);
  endtask

  // hold off the sender until every expected beat has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  task automatic send_random(brf_act_t act);
    send_beat(act, BYTE_W'($urandom), CNT_W'($urandom));
  endtask

  function automatic logic [CNT_W-1:0] pick_count();
    int r;
    r = $urandom_range(0, 9);
    if (r < 7) return CNT_W'($urandom_range(0, 16));
    if (r < 9) return CNT_W'($urandom_range(17, 64));
    return CNT_W'($urandom_range(65, 127));
  endfunction

  initial begin
    int r;
    sb = new();
    idle_on = 1'b0;
    rand_items = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_action = ACT_QUERY;
    in_write_byte = '0;
    in_read_count = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty cases, byte extremes, saturated and short reads, clear
    idle_on = 1'b1;
    send_beat(ACT_QUERY, 8'h3c, 7'd9);
    send_beat(ACT_READ, 8'h00, 7'd0);
    send_beat(ACT_READ, 8'hff, 7'd5);
    send_beat(ACT_WRITE, 8'h00, 7'd127);
    send_beat(ACT_WRITE, 8'hff, 7'd0);
    send_beat(ACT_WRITE, 8'ha5, 7'd64);
    send_beat(ACT_WRITE, 8'h5a, 7'd1);
    send_beat(ACT_READ, 8'h11, 7'd0);
    send_beat(ACT_QUERY, 8'h00, 7'd0);
    send_beat(ACT_READ, 8'h22, 7'd127);
    send_beat(ACT_WRITE, 8'h01, 7'd3);
    send_beat(ACT_WRITE, 8'h80, 7'd64);
    send_beat(ACT_WRITE, 8'h7f, 7'd65);
    send_beat(ACT_READ, 8'h33, 7'd2);
    send_beat(ACT_CLEAR, 8'hee, 7'd100);
    send_beat(ACT_QUERY, 8'h44, 7'd7);
    send_beat(ACT_READ, 8'h55, 7'd1);
    send_beat(ACT_WRITE, 8'hc3, 7'd0);
    send_beat(ACT_READ, 8'h66, 7'd64);
    send_beat(ACT_CLEAR, 8'h00, 7'd0);
    drain_results();

    // fill to full with random bytes, then overflow
    while (sb.held() < SLOTS - 1) begin
      if (rand_items % 40 == 0) idle_on = ($urandom_range(0, 3) != 0);
      r = $urandom_range(0, 99);
      if (r < 95) send_random(ACT_WRITE);
      else if (r < 98) send_random(ACT_QUERY);
      else send_beat(ACT_READ, BYTE_W'($urandom), CNT_W'($urandom_range(0, 3)));
      rand_items++;
    end
    repeat (3) begin
      send_random(ACT_WRITE);
      rand_items++;
    end
    send_random(ACT_QUERY);
    drain_results();
    send_beat(ACT_READ, BYTE_W'($urandom), CNT_W'($urandom_range(65, 127)));
    send_beat(ACT_READ, BYTE_W'($urandom), CNT_W'(MAX_BURST));
    rand_items += 3;

    // mixed traffic, calm at the tail
    while (rand_items < RANDOM_ITEMS) begin
      if (rand_items >= RANDOM_ITEMS - CALM_TAIL) idle_on = 1'b0;
      else if (rand_items % 30 == 0) idle_on = ($urandom_range(0, 3) != 0);
      r = $urandom_range(0, 99);
      if (r < 45) send_random(ACT_WRITE);
      else if (r < 75) send_beat(ACT_READ, BYTE_W'($urandom), pick_count());
      else if (r < 80) send_random(ACT_CLEAR);
      else send_random(ACT_QUERY);
      rand_items++;
    end
    in_valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
